// ===== hdl/masked_match_forwarding_table_top_defines.svh =====
// assertion macros for the forwarding table checker
`ifndef MASKED_MATCH_FORWARDING_TABLE_TOP_DEFINES_SVH
`define MASKED_MATCH_FORWARDING_TABLE_TOP_DEFINES_SVH

// clocked property, switched off while reset is high
`define MMFT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds through reset
`define MMFT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mmft_pkg.sv =====
// shared types and codes of the masked match forwarding table
package mmft_pkg;

   // default number of table entries
   localparam int TABLE_DEPTH = 16;

   // request kinds
   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_MISS   = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   // per-cell move codes
   localparam logic [1:0] MOVE_HOLD  = 2'd0;
   localparam logic [1:0] MOVE_SHIFT = 2'd1;
   localparam logic [1:0] MOVE_CLOSE = 2'd2;

   // one table entry, also used for the normalised query
   typedef struct packed {
      logic        valid;
      logic        is_v6;
      logic [63:0] dest_hi;
      logic [63:0] dest_lo;
      logic [63:0] mask_hi;
      logic [63:0] mask_lo;
      logic [7:0]  port;
   } entry_type;

endpackage

// ===== hdl/mmft_cell.sv =====
// one table cell: holds an entry, compares it and moves it along the chain
module mmft_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmp_en,
   input  logic               cmp_exact,
   input  mmft_pkg::entry_type query,
   input  logic [1:0]         move,
   input  mmft_pkg::entry_type from_up,
   input  mmft_pkg::entry_type from_down,
   output mmft_pkg::entry_type entry,
   output logic               match
);

   mmft_pkg::entry_type entry_ff, entry_in;
   logic                match_ff, match_in;
   logic                hit_masked;
   logic                hit_exact;

   // masked and exact compares against the query
   always_comb begin
      hit_masked = entry_ff.valid && (entry_ff.is_v6 == query.is_v6) &&
                   (((query.dest_hi ^ entry_ff.dest_hi) & entry_ff.mask_hi) == 64'd0) &&
                   (((query.dest_lo ^ entry_ff.dest_lo) & entry_ff.mask_lo) == 64'd0);
      hit_exact  = entry_ff.valid && (entry_ff.is_v6 == query.is_v6) &&
                   (entry_ff.dest_hi == query.dest_hi) &&
                   (entry_ff.dest_lo == query.dest_lo) &&
                   (entry_ff.mask_hi == query.mask_hi) &&
                   (entry_ff.mask_lo == query.mask_lo);
      match_in   = cmp_exact ? hit_exact : hit_masked;
   end

   // next entry from the neighbours
   always_comb begin
      case (move)
         mmft_pkg::MOVE_SHIFT: entry_in = from_up;
         mmft_pkg::MOVE_CLOSE: entry_in = from_down;
         default:              entry_in = entry_ff;
      endcase
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      entry_ff.is_v6   <= entry_in.is_v6;
      entry_ff.dest_hi <= entry_in.dest_hi;
      entry_ff.dest_lo <= entry_in.dest_lo;
      entry_ff.mask_hi <= entry_in.mask_hi;
      entry_ff.mask_lo <= entry_in.mask_lo;
      entry_ff.port    <= entry_in.port;
   end

   // compare result, captured when a beat is taken
   always_ff @(posedge clock) begin
      if (cmp_en) begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ===== hdl/mmft_pick.sv =====
// priority pick of the first matching cell
module mmft_pick #(
   parameter int TABLE_DEPTH = mmft_pkg::TABLE_DEPTH
) (
   input  logic [TABLE_DEPTH-1:0] match,
   input  logic [7:0]             cell_port [TABLE_DEPTH],
   output logic                   hit,
   output logic [TABLE_DEPTH-1:0] from_first,
   output logic [7:0]             port
);

   logic [TABLE_DEPTH-1:0] first;

   // lowest set bit is the highest priority; cells at or past it
   always_comb begin
      first      = match & (~match + TABLE_DEPTH'(1));
      from_first = ~(first - TABLE_DEPTH'(1));
      hit        = |match;
   end

   // port of the picked cell
   always_comb begin
      port = 8'd0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         port = port | (cell_port[i] & {8{first[i]}});
      end
   end

endmodule

// ===== hdl/masked_match_forwarding_table_top.sv =====
// top level of the masked match forwarding table
//
// Request channel (req_*): one beat is a lookup, an add or a remove, taken
// when req_valid is high and req_stall low. Response channel (rsp_*): one
// beat per request with a status and a port, taken when rsp_valid is high
// and rsp_stall low.
// The table is a chain of TABLE_DEPTH cells. In the cycle a request is
// taken every cell compares its entry with the query and keeps the result.
// When the output register is free, the first match is picked, the cells
// shift down (add, if not full) or close the gap (remove) from their
// neighbours, and the response is written to the output register.
// One request is in work at a time: a new request is taken only once the
// last one has passed its pick and update step. The next request may be
// taken while the last response still waits in the output register.
// When rsp_stall holds a finished response, the following request waits in
// its compare stage and req_stall stays high until the register frees.
// Reset empties the table and the output register.
module masked_match_forwarding_table_top #(
   parameter int TABLE_DEPTH = mmft_pkg::TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic        req_is_v6,
   input  logic [63:0] req_addr_hi,
   input  logic [63:0] req_addr_lo,
   input  logic [63:0] req_mask_hi,
   input  logic [63:0] req_mask_lo,
   input  logic [7:0]  req_port_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_port
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_BUSY = 1'b1;

   logic                state_ff, state_in;
   logic [1:0]          kind_ff;
   mmft_pkg::entry_type query_in, query_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_port_ff, rsp_port_in;
   logic                req_take;
   logic                finish;
   logic                full;
   logic                hit;
   logic [7:0]          pick_port;
   logic [TABLE_DEPTH-1:0] match_vec;
   logic [TABLE_DEPTH-1:0] from_first;
   logic [7:0]          cell_port [TABLE_DEPTH];
   logic [1:0]          cell_move [TABLE_DEPTH];
   mmft_pkg::entry_type cell_entry [TABLE_DEPTH];
   mmft_pkg::entry_type empty_entry;

   // handshake
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign finish    = (state_ff == S_BUSY) && (!rsp_valid_ff || !rsp_stall);

   // query with the unused ipv4 bits cleared
   always_comb begin
      query_in.valid   = 1'b1;
      query_in.is_v6   = req_is_v6;
      query_in.dest_hi = req_is_v6 ? req_addr_hi : 64'd0;
      query_in.dest_lo = req_is_v6 ? req_addr_lo : {32'd0, req_addr_lo[31:0]};
      query_in.mask_hi = req_is_v6 ? req_mask_hi : 64'd0;
      query_in.mask_lo = req_is_v6 ? req_mask_lo : {32'd0, req_mask_lo[31:0]};
      query_in.port    = req_port_id;
      empty_entry      = '0;
   end

   // held request beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff  <= req_kind;
         query_ff <= query_in;
      end
   end

   // chain of cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      mmft_pkg::entry_type up_entry;
      mmft_pkg::entry_type down_entry;

      if (i == 0) begin : g_head
         assign up_entry = query_ff;
      end else begin : g_mid_up
         assign up_entry = cell_entry[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign down_entry = empty_entry;
      end else begin : g_mid_down
         assign down_entry = cell_entry[i+1];
      end

      // move code for this cell
      always_comb begin
         cell_move[i] = mmft_pkg::MOVE_HOLD;
         if (finish && (kind_ff == mmft_pkg::KIND_ADD) && !full) begin
            cell_move[i] = mmft_pkg::MOVE_SHIFT;
         end else if (finish && (kind_ff == mmft_pkg::KIND_REMOVE) && from_first[i]) begin
            cell_move[i] = mmft_pkg::MOVE_CLOSE;
         end
      end

      mmft_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmp_en    (req_take),
         .cmp_exact (req_kind == mmft_pkg::KIND_REMOVE),
         .query     (query_in),
         .move      (cell_move[i]),
         .from_up   (up_entry),
         .from_down (down_entry),
         .entry     (cell_entry[i]),
         .match     (match_vec[i])
      );

      assign cell_port[i] = cell_entry[i].port;
   end

   assign full = cell_entry[TABLE_DEPTH-1].valid;

   mmft_pick #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_pick (
      .match      (match_vec),
      .cell_port  (cell_port),
      .hit        (hit),
      .from_first (from_first),
      .port       (pick_port)
   );

   // response beat
   always_comb begin
      rsp_status_in = mmft_pkg::ST_OK;
      rsp_port_in   = 8'd0;
      case (kind_ff)
         mmft_pkg::KIND_LOOKUP: begin
            rsp_status_in = hit ? mmft_pkg::ST_OK : mmft_pkg::ST_MISS;
            rsp_port_in   = hit ? pick_port : 8'd0;
         end
         mmft_pkg::KIND_ADD: begin
            rsp_status_in = full ? mmft_pkg::ST_FULL : mmft_pkg::ST_OK;
         end
         mmft_pkg::KIND_REMOVE: begin
            rsp_status_in = hit ? mmft_pkg::ST_OK : mmft_pkg::ST_ABSENT;
         end
         default: begin
            rsp_status_in = mmft_pkg::ST_OK;
         end
      endcase
   end

   // control state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_take) begin
         state_in = S_BUSY;
      end
      if (finish) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_port_ff   <= rsp_port_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_port   = rsp_port_ff;

endmodule

// ===== hdl/mmft_checker.sv =====
// port checker for the forwarding table, bound to the top level
`include "masked_match_forwarding_table_top_defines.svh"

module mmft_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_port
);

   // a held response beat keeps its payload
   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_port);
   endproperty

   // only a lookup hit carries a port
   property p_port_ok;
      rsp_valid && (rsp_port != 8'd0) |-> rsp_status == mmft_pkg::ST_OK;
   endproperty

   // a taken request blocks the next one
   property p_one_in_work;
      req_valid && !req_stall |=> req_stall;
   endproperty

   // no response in the cycle after a reset cycle
   property p_reset_empty;
      reset |=> !rsp_valid;
   endproperty

   `MMFT_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "response changed while stalled")

   `MMFT_ASSERT(a_port_ok, clock, reset, p_port_ok, "port given with failing status")

   `MMFT_ASSERT(a_one_in_work, clock, reset, p_one_in_work, "request taken while one is in work")

   `MMFT_ASSERT_ALWAYS(a_reset_empty, clock, p_reset_empty, "response beat after reset")

endmodule

bind masked_match_forwarding_table_top mmft_checker u_mmft_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_port   (rsp_port)
);
